@@ hdl/mst_pkg.sv @@
// Shared types, codes and the type-byte decode table for the MessagePack structure tracker.
// Used by the controller, the datapath and the top level.
package mst_pkg;

   localparam int DEFAULT_MAX_DEPTH = 16;

   localparam logic [1:0] ROLE_TYPE    = 2'd0;
   localparam logic [1:0] ROLE_LENGTH  = 2'd1;
   localparam logic [1:0] ROLE_PAYLOAD = 2'd2;

   localparam logic [3:0] KIND_UINT  = 4'd0;
   localparam logic [3:0] KIND_INT   = 4'd1;
   localparam logic [3:0] KIND_FLOAT = 4'd2;
   localparam logic [3:0] KIND_NIL   = 4'd3;
   localparam logic [3:0] KIND_UNDEF = 4'd4;
   localparam logic [3:0] KIND_BOOL  = 4'd5;
   localparam logic [3:0] KIND_BIN   = 4'd6;
   localparam logic [3:0] KIND_EXT   = 4'd7;
   localparam logic [3:0] KIND_STR   = 4'd8;
   localparam logic [3:0] KIND_ARRAY = 4'd9;
   localparam logic [3:0] KIND_MAP   = 4'd10;

   localparam logic [7:0] FIXMAP_BASE = 8'h80;
   localparam logic [7:0] NEGFIX_BASE = 8'hE0;

   typedef struct packed {
      logic [3:0] kind;
      logic [2:0] hdr;     // length field bytes that follow
      logic [3:0] pay;     // fixed payload bytes that follow
      logic       fixlen;  // length comes from the type byte
      logic [4:0] flen;
   } type_dec_type;

   // controller -> datapath
   typedef struct packed {
      logic decode;    // take the word on the input channel
      logic pop;       // drop the top level
      logic dec_top;   // decrement the top count
      logic set_root;
      logic emit;      // load the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic dec_done;   // word being decoded completes an element
      logic level_zero;
      logic top_one;
      logic out_free;
   } status_type;

   function automatic type_dec_type decode_type(input logic [7:0] b);
      type_dec_type d;
      d = '0;
      if (b < FIXMAP_BASE) begin
         d.kind = KIND_UINT;
      end else if (b >= NEGFIX_BASE) begin
         d.kind = KIND_INT;
      end else if (b < 8'h90) begin
         d.kind = KIND_MAP;   d.fixlen = 1'b1; d.flen = {1'b0, b[3:0]};
      end else if (b < 8'hA0) begin
         d.kind = KIND_ARRAY; d.fixlen = 1'b1; d.flen = {1'b0, b[3:0]};
      end else if (b < 8'hC0) begin
         d.kind = KIND_STR;   d.fixlen = 1'b1; d.flen = b[4:0];
      end else begin
         case (b)
            8'hC0: d.kind = KIND_NIL;
            8'hC1: d.kind = KIND_UNDEF;
            8'hC2, 8'hC3: d.kind = KIND_BOOL;
            8'hC4: begin d.kind = KIND_BIN;   d.hdr = 3'd1; end
            8'hC5: begin d.kind = KIND_BIN;   d.hdr = 3'd2; end
            8'hC6: begin d.kind = KIND_BIN;   d.hdr = 3'd4; end
            8'hC7: begin d.kind = KIND_EXT;   d.hdr = 3'd1; end
            8'hC8: begin d.kind = KIND_EXT;   d.hdr = 3'd2; end
            8'hC9: begin d.kind = KIND_EXT;   d.hdr = 3'd4; end
            8'hCA: begin d.kind = KIND_FLOAT; d.pay = 4'd4; end
            8'hCB: begin d.kind = KIND_FLOAT; d.pay = 4'd8; end
            8'hCC: begin d.kind = KIND_UINT;  d.pay = 4'd1; end
            8'hCD: begin d.kind = KIND_UINT;  d.pay = 4'd2; end
            8'hCE: begin d.kind = KIND_UINT;  d.pay = 4'd4; end
            8'hCF: begin d.kind = KIND_UINT;  d.pay = 4'd8; end
            8'hD0: begin d.kind = KIND_INT;   d.pay = 4'd1; end
            8'hD1: begin d.kind = KIND_INT;   d.pay = 4'd2; end
            8'hD2: begin d.kind = KIND_INT;   d.pay = 4'd4; end
            8'hD3: begin d.kind = KIND_INT;   d.pay = 4'd8; end
            8'hD4: begin d.kind = KIND_EXT; d.fixlen = 1'b1; d.flen = 5'd1;  end
            8'hD5: begin d.kind = KIND_EXT; d.fixlen = 1'b1; d.flen = 5'd2;  end
            8'hD6: begin d.kind = KIND_EXT; d.fixlen = 1'b1; d.flen = 5'd4;  end
            8'hD7: begin d.kind = KIND_EXT; d.fixlen = 1'b1; d.flen = 5'd8;  end
            8'hD8: begin d.kind = KIND_EXT; d.fixlen = 1'b1; d.flen = 5'd16; end
            8'hD9: begin d.kind = KIND_STR;   d.hdr = 3'd1; end
            8'hDA: begin d.kind = KIND_STR;   d.hdr = 3'd2; end
            8'hDB: begin d.kind = KIND_STR;   d.hdr = 3'd4; end
            8'hDC: begin d.kind = KIND_ARRAY; d.hdr = 3'd2; end
            8'hDD: begin d.kind = KIND_ARRAY; d.hdr = 3'd4; end
            8'hDE: begin d.kind = KIND_MAP;   d.hdr = 3'd2; end
            default: begin d.kind = KIND_MAP; d.hdr = 3'd4; end
         endcase
      end
      return d;
   endfunction

endpackage

@@ hdl/mst_ctrl.sv @@
// Sequencer for the structure tracker: decode, level pops, output hand-off.
// Depends on mst_pkg.
module mst_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  mst_pkg::status_type st,
   output mst_pkg::cmd_type    cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_POP  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.decode = 1'b1;
               state_in   = st.dec_done ? S_POP : S_EMIT;
            end
         end
         S_POP: begin
            // one level per cycle until a count stays nonzero or the stack empties
            if (st.level_zero) begin
               cmd.set_root = 1'b1;
               state_in     = S_EMIT;
            end else if (st.top_one) begin
               cmd.pop = 1'b1;
            end else begin
               cmd.dec_top = 1'b1;
               state_in    = S_EMIT;
            end
         end
         S_EMIT: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ hdl/mst_datapath.sv @@
// Datapath of the structure tracker: length/payload counters, child-count stack,
// result register and configuration register. Depends on mst_pkg.
module mst_datapath #(
   parameter int MAX_DEPTH = mst_pkg::DEFAULT_MAX_DEPTH,
   parameter int DEPTH_W   = $clog2(MAX_DEPTH + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [7:0]         in_byte,
   input  logic               csr_valid,
   input  logic               csr_data,
   input  mst_pkg::cmd_type    cmd,
   output mst_pkg::status_type st,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [1:0]         out_role,
   output logic [3:0]         out_kind,
   output logic [DEPTH_W-1:0] out_depth,
   output logic [31:0]        out_len,
   output logic               out_len_valid,
   output logic               out_done,
   output logic               out_root,
   output logic               out_error
);

   localparam int IDX_W = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

   logic [32:0]        counts_ff [MAX_DEPTH];
   logic [DEPTH_W-1:0] level_ff, level_in;
   logic [2:0]         hl_ff, hl_in;
   logic [31:0]        acc_ff, acc_in;
   logic [32:0]        pl_ff, pl_in;
   logic [3:0]         kind_ff, kind_in;
   logic               err_ff, err_in;
   logic               nest_ff;

   // result being built
   logic [1:0]  r_role_ff, r_role_in;
   logic [31:0] r_len_ff, r_len_in;
   logic        r_lv_ff, r_lv_in;
   logic        r_done_ff, r_done_in;
   logic        r_root_ff;

   logic               push;
   logic [32:0]        push_cnt;
   logic [IDX_W-1:0]   top_idx;
   logic [32:0]        top_cnt;
   mst_pkg::type_dec_type d;
   logic               fin;
   logic [31:0]        fin_len;

   logic               ov_ff;

   assign d       = mst_pkg::decode_type(in_byte);
   assign top_idx = IDX_W'(level_ff - DEPTH_W'(1));
   assign top_cnt = counts_ff[top_idx];

   always_comb begin
      level_in  = level_ff;
      hl_in     = hl_ff;
      acc_in    = acc_ff;
      pl_in     = pl_ff;
      kind_in   = kind_ff;
      err_in    = err_ff;
      r_role_in = mst_pkg::ROLE_TYPE;
      r_len_in  = '0;
      r_lv_in   = 1'b0;
      r_done_in = 1'b0;
      fin       = 1'b0;
      fin_len   = '0;
      push      = 1'b0;
      push_cnt  = '0;
      if (hl_ff != 3'd0) begin
         r_role_in = mst_pkg::ROLE_LENGTH;
         acc_in    = {acc_ff[23:0], in_byte};
         hl_in     = hl_ff - 3'd1;
         if (hl_ff == 3'd1) begin
            fin     = 1'b1;
            fin_len = acc_in;
         end
      end else if (pl_ff != 33'd0) begin
         r_role_in = mst_pkg::ROLE_PAYLOAD;
         pl_in     = pl_ff - 33'd1;
         r_done_in = (pl_ff == 33'd1);
      end else begin
         kind_in = d.kind;
         if (d.hdr != 3'd0) begin
            hl_in  = d.hdr;
            acc_in = '0;
         end else if (d.fixlen) begin
            fin     = 1'b1;
            fin_len = {27'd0, d.flen};
         end else if (d.pay != 4'd0) begin
            pl_in = {29'd0, d.pay};
         end else begin
            r_done_in = 1'b1;
         end
      end
      if (fin) begin
         r_lv_in  = 1'b1;
         r_len_in = fin_len;
         case (kind_in)
            mst_pkg::KIND_STR, mst_pkg::KIND_BIN: begin
               pl_in     = {1'b0, fin_len};
               r_done_in = (fin_len == 32'd0);
            end
            mst_pkg::KIND_EXT: begin
               pl_in = {1'b0, fin_len} + 33'd1;  // ext type byte counts as payload
            end
            mst_pkg::KIND_ARRAY, mst_pkg::KIND_MAP: begin
               push_cnt = (kind_in == mst_pkg::KIND_MAP) ? {fin_len, 1'b0} : {1'b0, fin_len};
               if (!nest_ff || push_cnt == 33'd0) begin
                  r_done_in = 1'b1;
               end else if (level_ff >= DEPTH_W'(MAX_DEPTH)) begin
                  err_in    = 1'b1;
                  r_done_in = 1'b1;
               end else begin
                  push     = 1'b1;
                  level_in = level_ff + DEPTH_W'(1);
               end
            end
            default: r_done_in = 1'b1;
         endcase
      end
   end

   always_comb begin
      st.dec_done   = r_done_in;
      st.level_zero = (level_ff == '0);
      st.top_one    = (top_cnt == 33'd1);
      st.out_free   = !ov_ff || out_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff  <= '0;
         hl_ff     <= '0;
         acc_ff    <= '0;
         pl_ff     <= '0;
         kind_ff   <= mst_pkg::KIND_UINT;
         err_ff    <= 1'b0;
         nest_ff   <= 1'b1;
         ov_ff     <= 1'b0;
         r_root_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            nest_ff <= csr_data;
         end
         if (cmd.decode) begin
            level_ff  <= level_in;
            hl_ff     <= hl_in;
            acc_ff    <= acc_in;
            pl_ff     <= pl_in;
            kind_ff   <= kind_in;
            err_ff    <= err_in;
            r_root_ff <= 1'b0;
         end
         if (cmd.pop) begin
            level_ff <= level_ff - DEPTH_W'(1);
         end
         if (cmd.set_root) begin
            r_root_ff <= 1'b1;
         end
         if (cmd.emit) begin
            ov_ff <= 1'b1;
         end else if (out_ready) begin
            ov_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.decode) begin
         r_role_ff <= r_role_in;
         r_len_ff  <= r_len_in;
         r_lv_ff   <= r_lv_in;
         r_done_ff <= r_done_in;
         if (push) begin
            counts_ff[level_ff[IDX_W-1:0]] <= push_cnt;
         end
      end
      if (cmd.dec_top) begin
         counts_ff[top_idx] <= top_cnt - 33'd1;
      end
      if (cmd.emit) begin
         out_role      <= r_role_ff;
         out_kind      <= kind_ff;
         out_depth     <= level_ff;
         out_len       <= r_len_ff;
         out_len_valid <= r_lv_ff;
         out_done      <= r_done_ff;
         out_root      <= r_root_ff;
         out_error     <= err_ff;
      end
   end

   assign out_valid = ov_ff;

endmodule

@@ hdl/msgpack_stream_structure_tracker_top.sv @@
// Top level of the MessagePack stream structure tracker.
// Instantiates mst_ctrl and mst_datapath; depends on mst_pkg.
//
// Usage:
//   req_*  : one encoded stream byte per word in req_tdata.
//   rsp_*  : one result word per input word, in order. rsp_tuser carries the
//            byte role and value kind, rsp_tdata the depth, length and flags.
//   csr_*  : write of track_nesting (csr_data), taken whenever csr_valid is
//            high; write it only while no word is in flight.
// Timing: a word is taken in the idle state and its result is registered; it is
// then loaded into the output register in the emit state. A byte that completes
// an element first walks the child-count stack one level per cycle.
// The output register holds its word while rsp_tready is low; the next byte is
// taken meanwhile, and its result waits until the register is freed.
// Reset clears the stack level, counters and sticky error and sets
// track_nesting to 1; no stack clearing pass is needed.
module msgpack_stream_structure_tracker_top #(
   parameter  int MAX_DEPTH = mst_pkg::DEFAULT_MAX_DEPTH,
   localparam int DEPTH_W   = $clog2(MAX_DEPTH + 1),
   localparam int RSP_DW    = ((DEPTH_W + 36 + 7) / 8) * 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // stream_byte
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   // nest_depth, length_value[31:0], length_valid, element_done, root_done,
   // error_flag, zero fill
   output logic [RSP_DW-1:0] rsp_tdata,
   output logic [5:0]        rsp_tuser,   // byte_role[1:0], value_kind[3:0]
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic              csr_data     // track_nesting
);

   mst_pkg::cmd_type    cmd;
   mst_pkg::status_type st;

   logic [1:0]         role;
   logic [3:0]         kind;
   logic [DEPTH_W-1:0] depth;
   logic [31:0]        len;
   logic               len_valid, done, root, err;

   assign csr_ready = 1'b1;

   mst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   mst_datapath #(
      .MAX_DEPTH (MAX_DEPTH),
      .DEPTH_W   (DEPTH_W)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .in_byte       (req_tdata),
      .csr_valid     (csr_valid),
      .csr_data      (csr_data),
      .cmd           (cmd),
      .st            (st),
      .out_valid     (rsp_tvalid),
      .out_ready     (rsp_tready),
      .out_role      (role),
      .out_kind      (kind),
      .out_depth     (depth),
      .out_len       (len),
      .out_len_valid (len_valid),
      .out_done      (done),
      .out_root      (root),
      .out_error     (err)
   );

   assign rsp_tuser = {kind, role};
   assign rsp_tdata = RSP_DW'({err, root, done, len_valid, len, depth});

endmodule

@@ hdl/mst_checker.sv @@
// Port-level checks for the structure tracker result channel, bound to the top.
// Depends on msgpack_stream_structure_tracker_top and mst_pkg.
module mst_checker #(
   parameter int DEPTH_W = 5,
   parameter int RSP_DW  = 48
) (
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic [5:0]        rsp_tuser
);

   logic [1:0] role;
   logic       lv, done, root;

   assign role = rsp_tuser[1:0];
   assign lv   = rsp_tdata[DEPTH_W + 32];
   assign done = rsp_tdata[DEPTH_W + 33];
   assign root = rsp_tdata[DEPTH_W + 34];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   a_root_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && root |-> done && rsp_tdata[DEPTH_W-1:0] == '0)
      else $error("root completion without element completion at depth zero");

   a_len_role: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && lv |-> role == mst_pkg::ROLE_TYPE || role == mst_pkg::ROLE_LENGTH)
      else $error("length reported on a payload byte");

   a_role_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> role <= mst_pkg::ROLE_PAYLOAD)
      else $error("undefined byte role");

endmodule

bind msgpack_stream_structure_tracker_top mst_checker #(
   .DEPTH_W (DEPTH_W),
   .RSP_DW  (RSP_DW)
) u_mst_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

@@ bench/msgpack_stream_structure_tracker_top_tb.sv @@
// Testbench for msgpack_stream_structure_tracker_top: random and directed MessagePack
// streams, a built-in structure predictor and an in-order result checker.
// Depends on mst_pkg and the top level RTL.
`timescale 1ns / 1ps

module msgpack_stream_structure_tracker_top_tb;

   localparam int MAX_DEPTH = mst_pkg::DEFAULT_MAX_DEPTH;
   localparam int RSP_DW    = 48;
   localparam int DRAIN     = MAX_DEPTH + 8;
   localparam int PHASE_BYTES = 130;

   typedef struct packed {
      logic [1:0]  role;
      logic [3:0]  kind;
      logic [4:0]  depth;
      logic [31:0] len;
      logic        len_ok;
      logic        done;
      logic        root;
      logic        err;
   } track_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [7:0]        req_tdata = 8'h00;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic [RSP_DW-1:0] rsp_tdata;
   logic [5:0]        rsp_tuser;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic              csr_data = 1'b0;

   msgpack_stream_structure_tracker_top DUT (.*);

   always #5 clock = ~clock;

   // stimulus and expectation stores
   logic [7:0]     stream_q[$];
   track_word_type track_q[$];
   int             idle_pct = 19;
   int             errors = 0;
   int             words_out = 0;
   int             roots_seen = 0;
   logic           req_fire = 1'b0;

   // predictor state
   logic [32:0] child_left[MAX_DEPTH];
   int          level;
   int          hdr_left;
   logic [31:0] len_acc;
   logic [32:0] pay_left;
   logic [3:0]  cur_kind;
   logic        err_sticky;
   logic        nest_on;

   task automatic put_byte(logic [7:0] b);
      stream_q = {stream_q, b};
   endtask

   function automatic logic pop_levels();
      while (level > 0) begin
         if (child_left[level-1] - 33'd1 != 33'd0) begin
            child_left[level-1] = child_left[level-1] - 33'd1;
            return 1'b0;
         end
         level--;
      end
      return 1'b1;
   endfunction

   function automatic logic close_header(logic [31:0] n);
      logic [32:0] cnt;
      case (cur_kind)
         mst_pkg::KIND_STR, mst_pkg::KIND_BIN: begin
            pay_left = {1'b0, n};
            return n == 0;
         end
         mst_pkg::KIND_EXT: begin
            pay_left = {1'b0, n} + 33'd1;
            return 1'b0;
         end
         mst_pkg::KIND_ARRAY, mst_pkg::KIND_MAP: begin
            if (!nest_on) return 1'b1;
            cnt = (cur_kind == mst_pkg::KIND_MAP) ? {n, 1'b0} : {1'b0, n};
            if (cnt == 0) return 1'b1;
            if (level >= MAX_DEPTH) begin
               err_sticky = 1'b1;
               return 1'b1;
            end
            child_left[level] = cnt;
            level++;
            return 1'b0;
         end
         default: return 1'b1;
      endcase
   endfunction

   function automatic track_word_type track_byte(logic [7:0] b);
      track_word_type w;
      mst_pkg::type_dec_type d;
      w = '0;
      if (hdr_left > 0) begin
         w.role = mst_pkg::ROLE_LENGTH;
         len_acc = {len_acc[23:0], b};
         hdr_left--;
         if (hdr_left == 0) begin
            w.len_ok = 1'b1;
            w.len = len_acc;
            w.done = close_header(len_acc);
         end
      end else if (pay_left > 0) begin
         w.role = mst_pkg::ROLE_PAYLOAD;
         pay_left = pay_left - 33'd1;
         w.done = (pay_left == 0);
      end else begin
         w.role = mst_pkg::ROLE_TYPE;
         // own table: kind / length-field bytes / fixed payload / embedded length
         d = '0;
         if (b < 8'h80) d.kind = mst_pkg::KIND_UINT;
         else if (b >= 8'hE0) d.kind = mst_pkg::KIND_INT;
         else if (b < 8'h90) begin
            d.kind = mst_pkg::KIND_MAP; d.fixlen = 1'b1; d.flen = {1'b0, b[3:0]};
         end
         else if (b < 8'hA0) begin
            d.kind = mst_pkg::KIND_ARRAY; d.fixlen = 1'b1; d.flen = {1'b0, b[3:0]};
         end
         else if (b < 8'hC0) begin
            d.kind = mst_pkg::KIND_STR; d.fixlen = 1'b1; d.flen = b[4:0];
         end
         else if (b == 8'hC0) d.kind = mst_pkg::KIND_NIL;
         else if (b == 8'hC1) d.kind = mst_pkg::KIND_UNDEF;
         else if (b <= 8'hC3) d.kind = mst_pkg::KIND_BOOL;
         else if (b <= 8'hC6) begin
            d.kind = mst_pkg::KIND_BIN; d.hdr = 3'd1 << (b - 8'hC4);
         end
         else if (b <= 8'hC9) begin
            d.kind = mst_pkg::KIND_EXT; d.hdr = 3'd1 << (b - 8'hC7);
         end
         else if (b <= 8'hCB) begin
            d.kind = mst_pkg::KIND_FLOAT; d.pay = 4'd4 << (b - 8'hCA);
         end
         else if (b <= 8'hCF) begin
            d.kind = mst_pkg::KIND_UINT; d.pay = 4'd1 << (b - 8'hCC);
         end
         else if (b <= 8'hD3) begin
            d.kind = mst_pkg::KIND_INT; d.pay = 4'd1 << (b - 8'hD0);
         end
         else if (b <= 8'hD8) begin
            d.kind = mst_pkg::KIND_EXT; d.fixlen = 1'b1; d.flen = 5'd1 << (b - 8'hD4);
         end
         else if (b <= 8'hDB) begin
            d.kind = mst_pkg::KIND_STR; d.hdr = 3'd1 << (b - 8'hD9);
         end
         else if (b <= 8'hDD) begin
            d.kind = mst_pkg::KIND_ARRAY; d.hdr = 3'd2 << (b - 8'hDC);
         end
         else begin
            d.kind = mst_pkg::KIND_MAP; d.hdr = 3'd2 << (b - 8'hDE);
         end
         cur_kind = d.kind;
         if (d.hdr != 0) begin
            hdr_left = int'(d.hdr);
            len_acc = '0;
         end else if (d.fixlen) begin
            w.len_ok = 1'b1;
            w.len = {27'd0, d.flen};
            w.done = close_header({27'd0, d.flen});
         end else if (d.pay != 0) begin
            pay_left = {29'd0, d.pay};
         end else begin
            w.done = 1'b1;
         end
      end
      if (w.done) w.root = pop_levels();
      w.kind = cur_kind;
      w.depth = 5'(level);
      w.err = err_sticky;
      return w;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $realtime, name, want, got);
      end
   endtask

   // monitor and predictor update
   always @(posedge clock) begin
      track_word_type want, got;
      if (reset) begin
         level = 0; hdr_left = 0; len_acc = '0; pay_left = '0;
         cur_kind = mst_pkg::KIND_UINT; err_sticky = 1'b0; nest_on = 1'b1;
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (csr_valid && csr_ready) nest_on = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.role = rsp_tuser[1:0];
            got.kind = rsp_tuser[5:2];
            got.depth = rsp_tdata[4:0];
            got.len = rsp_tdata[36:5];
            got.len_ok = rsp_tdata[37];
            got.done = rsp_tdata[38];
            got.root = rsp_tdata[39];
            got.err = rsp_tdata[40];
            words_out++;
            if (track_q.size() == 0) begin
               errors++;
               $display("%0t: unexpected word, expected none, actual %h", $realtime, got);
            end else begin
               want = track_q.pop_front();
               if (want.root) roots_seen++;
               check_field("byte_role", 32'(want.role), 32'(got.role));
               check_field("value_kind", 32'(want.kind), 32'(got.kind));
               check_field("nest_depth", 32'(want.depth), 32'(got.depth));
               check_field("length_value", want.len, got.len);
               check_field("length_valid", 32'(want.len_ok), 32'(got.len_ok));
               check_field("element_done", 32'(want.done), 32'(got.done));
               check_field("root_done", 32'(want.root), 32'(got.root));
               check_field("error_flag", 32'(want.err), 32'(got.err));
            end
         end
         if (req_tvalid && req_tready) track_q = {track_q, track_byte(req_tdata)};
      end
   end

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            if (stream_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
               req_tvalid <= 1'b1;
               req_tdata <= stream_q.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= idle_pct);
      end
   end

   task automatic push_rand(int n);
      repeat (n) put_byte(8'($urandom_range(255)));
   endtask

   task automatic push_len(int nbytes, int n);
      for (int i = nbytes - 1; i >= 0; i--) put_byte(8'(n >> (8 * i)));
   endtask

   // one well-formed value with random content
   task automatic gen_value(int lvl);
      int sel, n, w;
      sel = $urandom_range(15);
      if (lvl >= 3 && sel >= 9) sel = sel - 9;
      n = $urandom_range(3);
      case (sel)
         0: put_byte(8'($urandom_range(8'h7F)));
         1: put_byte(8'($urandom_range(8'hFF, 8'hE0)));
         2: put_byte(8'($urandom_range(8'hC3, 8'hC0)));
         3: begin
            w = $urandom_range(8'hD3, 8'hCA);
            put_byte(8'(w));
            push_rand(w <= 8'hCB ? 4 << (w - 8'hCA) :
                      w <= 8'hCF ? 1 << (w - 8'hCC) : 1 << (w - 8'hD0));
         end
         4: begin
            n = $urandom_range(5);
            put_byte(8'(8'hA0 | n));
            push_rand(n);
         end
         5, 6: begin
            w = $urandom_range(2);
            put_byte(8'($urandom_range(1) ? 8'hD9 + w : 8'hC4 + w));
            push_len(1 << w, n);
            push_rand(n);
         end
         7: begin
            w = $urandom_range(2);
            put_byte(8'(8'hC7 + w));
            push_len(1 << w, n);
            push_rand(n + 1);
         end
         8: begin
            w = $urandom_range(4);
            put_byte(8'(8'hD4 + w));
            push_rand((1 << w) + 1);
         end
         9, 10, 11: begin
            w = $urandom_range(2);
            if (w == 0) put_byte(8'(8'h90 | n));
            else begin
               put_byte(8'(8'hDB + w));
               push_len(2 * w, n);
            end
            repeat (n) gen_value(lvl + 1);
         end
         default: begin
            w = $urandom_range(2);
            if (w == 0) put_byte(8'(8'h80 | n));
            else begin
               put_byte(8'(8'hDD + w));
               push_len(2 * w, n);
            end
            repeat (2 * n) gen_value(lvl + 1);
         end
      endcase
   endtask

   task automatic drain_all();
      while (stream_q.size() > 0 || req_tvalid || track_q.size() > 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_mode(logic mode);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= mode;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, nesting on: extremes, all scalar kinds, long headers, cascade
      put_byte(8'h00); put_byte(8'h7F); put_byte(8'hE0); put_byte(8'hFF);
      put_byte(8'hC0); put_byte(8'hC1); put_byte(8'hC2); put_byte(8'hC3);
      put_byte(8'hCF); push_rand(8);
      put_byte(8'hCA); push_rand(4);
      put_byte(8'hD8); push_rand(17);
      put_byte(8'hC7); push_len(1, 2); push_rand(3);
      put_byte(8'hC6); push_len(4, 1); push_rand(1);
      put_byte(8'hBF); push_rand(31);
      put_byte(8'hA0);
      put_byte(8'h90);
      put_byte(8'h80);
      put_byte(8'hDE); push_len(2, 1); put_byte(8'hC0);
      put_byte(8'hC0);
      // nested arrays that all close on one byte
      put_byte(8'h92); put_byte(8'h91); put_byte(8'h90);
      put_byte(8'h91); put_byte(8'h91); put_byte(8'hC3);
      drain_all();

      // standalone headers, full-width counts
      write_mode(1'b0);
      put_byte(8'hDD); push_len(4, -1);
      put_byte(8'hDF); push_len(4, -1);
      put_byte(8'hDF); push_len(4, 32'h5555AAAA);
      put_byte(8'h8F);
      put_byte(8'h9F);
      drain_all();

      // random phases with alternating mode; the third one without idling
      for (int ph = 0; ph < 4; ph++) begin
         write_mode(ph[0] == 0);
         idle_pct = (ph == 2) ? 0 : 19;
         while (stream_q.size() < PHASE_BYTES) begin
            if ($urandom_range(9) == 0) begin
               // noise that cannot open a huge payload or count
               int nb;
               nb = $urandom_range(255);
               if (nb inside {8'hC5, 8'hC6, 8'hC8, 8'hC9, 8'hDA, 8'hDB, 8'hDD, 8'hDF})
                  nb = 8'hC0;
               put_byte(8'(nb));
            end else begin
               gen_value(0);
            end
         end
         drain_all();
      end

      // stack overflow sets the sticky error; all levels then close together
      write_mode(1'b1);
      idle_pct = 19;
      repeat (MAX_DEPTH + 1) put_byte(8'h91);
      put_byte(8'h01);
      put_byte(8'hC3);
      drain_all();

      $display("Covered %0d result words and %0d completed top-level values,",
               words_out, roots_seen);
      $display("in both nesting modes, with random stalls and one overflow case.");
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAIL");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/mst_pkg.sv
hdl/mst_ctrl.sv
hdl/mst_datapath.sv
hdl/msgpack_stream_structure_tracker_top.sv
hdl/mst_checker.sv
bench/msgpack_stream_structure_tracker_top_tb.sv
